### rtl/gdec_pkg.sv
// Shared types, constants and register codes for the gadget decomposition block.
package gdec_pkg;

    localparam int X_W      = 64;   // torus coefficient width
    localparam int DIGIT_W  = 50;   // widest digit, also widest precision
    localparam int K_W      = 6;    // digit_bits / digit_count width
    localparam int CNT_W    = 7;    // slices_requested width
    localparam int IDX_W    = 6;    // slice_index width
    localparam int PROD_W   = 12;   // digit_bits * digit_count
    localparam int QDEPTH   = 4;    // front-to-back queue entries

    localparam int DEF_MAX_SLICES    = 64;
    localparam int DEF_MAX_PRECISION = 50;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_BITS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DIGIT_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SLICES      = 2'd2;

    localparam logic [K_W-1:0]   RST_DIGIT_BITS  = 6'd10;
    localparam logic [K_W-1:0]   RST_DIGIT_COUNT = 6'd3;
    localparam logic [CNT_W-1:0] RST_SLICES      = 7'd3;

    typedef struct packed {
        logic [X_W-1:0] torus_value;
        logic           last_coeff;
    } t_in_item;

    typedef struct packed {
        logic signed [DIGIT_W-1:0] digit;
        logic [IDX_W-1:0]          slice_index;
        logic                      last_digit;
        logic                      poly_end;
        logic                      config_error;
    } t_out_item;

    // one classified coefficient, offset sum left-aligned in work
    typedef struct packed {
        logic [DIGIT_W-1:0] work;
        logic [K_W-1:0]     k;
        logic [K_W-1:0]     ell;
        logic [CNT_W-1:0]   cnt;
        logic               err;
        logic               pend;
    } t_work;

endpackage

### rtl/gdec_front.sv
// Front end: config registers, rounding and offset add, three pipeline stages.
module gdec_front
    import gdec_pkg::*;
#(
    parameter int MAX_SLICES    = DEF_MAX_SLICES,
    parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_push,
    input  t_in_item              i_in,
    output logic                  o_full,
    output logic                  o_wr,
    output t_work                 o_wdata,
    input  logic                  i_q_full
);

    logic [K_W-1:0]   r_digit_bits;
    logic [K_W-1:0]   r_digit_count;
    logic [CNT_W-1:0] r_slices;

    // stage 1: captured item and derived config
    logic               r1_v;
    logic [X_W-1:0]     r1_x;
    logic [K_W-1:0]     r1_L;
    logic [DIGIT_W-1:0] r1_offs;
    t_work              r1_w;
    // stage 2: truncated value and rounding bits
    logic               r2_v;
    logic [DIGIT_W-1:0] r2_q;
    logic               r2_rnd;
    logic               r2_sticky;
    logic [K_W-1:0]     r2_L;
    logic [DIGIT_W-1:0] r2_offs;
    t_work              r2_w;
    // stage 3: result for the queue
    logic               r3_v;
    t_work              r3_w;

    logic                  en;
    logic                  acc;
    logic [PROD_W-1:0]     prod;
    logic                  err;
    logic [DIGIT_W-1:0]    n_offs;
    logic [PROD_W-1:0]     pos;
    logic [X_W-1:0]        shl;
    logic [DIGIT_W-1:0]    n_q;
    logic                  inc;
    logic [DIGIT_W:0]      sum_w;
    logic [DIGIT_W:0]      lmask;
    logic [DIGIT_W-1:0]    sum;
    t_work                 n_w3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_bits  <= RST_DIGIT_BITS;
            r_digit_count <= RST_DIGIT_COUNT;
            r_slices      <= RST_SLICES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_DIGIT_BITS:  r_digit_bits  <= i_cfg_wdata[K_W-1:0];
                REG_DIGIT_COUNT: r_digit_count <= i_cfg_wdata[K_W-1:0];
                REG_SLICES:      r_slices      <= i_cfg_wdata;
                default:         ;
            endcase
        end
    end

    assign en     = !r3_v || !i_q_full;
    assign acc    = i_push && en;
    assign o_full = !en;
    assign o_wr   = r3_v && !i_q_full;
    assign o_wdata = r3_w;

    // stage 1 logic: precision check and offset mask, one bit per digit top
    always_comb begin
        prod = PROD_W'(r_digit_bits) * PROD_W'(r_digit_count);
        err  = (r_digit_bits == '0) || (r_digit_count == '0)
            || (prod > PROD_W'(MAX_PRECISION));
        n_offs = '0;
        pos    = '0;
        for (int j = 0; j < DIGIT_W; j++) begin
            pos = PROD_W'(j + 1) * PROD_W'(r_digit_bits) - PROD_W'(1);
            if ((K_W'(j) < r_digit_count) && (pos < PROD_W'(DIGIT_W))) begin
                n_offs[pos[K_W-1:0]] = 1'b1;
            end
        end
    end

    // stage 2 logic: keep top L bits, round bit and sticky from the rest
    always_comb begin
        n_q = DIGIT_W'(r1_x >> (7'd64 - {1'b0, r1_L}));
        shl = r1_x << r1_L;
    end

    // stage 3 logic: ties go to even low bit of the offset sum
    always_comb begin
        inc   = r2_rnd && (r2_sticky || (r2_q[0] ^ r2_offs[0]));
        sum_w = {1'b0, r2_q} + {1'b0, r2_offs} + (DIGIT_W+1)'(inc);
        lmask = ((DIGIT_W+1)'(1) << r2_L) - (DIGIT_W+1)'(1);
        sum   = DIGIT_W'(sum_w & lmask);
        n_w3  = r2_w;
        n_w3.work = r2_w.err ? '0 : (sum << (K_W'(DIGIT_W) - r2_L));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= acc;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x      <= i_in.torus_value;
            r1_L      <= prod[K_W-1:0];
            r1_offs   <= n_offs;
            r1_w.work <= '0;
            r1_w.k    <= r_digit_bits;
            r1_w.ell  <= r_digit_count;
            r1_w.cnt  <= (r_slices > CNT_W'(MAX_SLICES)) ? CNT_W'(MAX_SLICES) : r_slices;
            r1_w.err  <= err;
            r1_w.pend <= i_in.last_coeff;

            r2_q      <= n_q;
            r2_rnd    <= shl[X_W-1];
            r2_sticky <= |shl[X_W-2:0];
            r2_L      <= r1_L;
            r2_offs   <= r1_offs;
            r2_w      <= r1_w;

            r3_w      <= n_w3;
        end
    end

endmodule

### rtl/gdec_queue.sv
// Small flop queue between front end and slice sequencer.
module gdec_queue
    import gdec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_work i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_work o_rdata,
    output logic  o_empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_Q = $clog2(QDEPTH + 1);

    t_work              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_Q-1:0]   r_cnt;
    logic [CNT_Q-1:0]   n_cnt;
    logic               wr;
    logic               rd;

    assign o_full  = (r_cnt == CNT_Q'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_wr && !o_full;
    assign rd      = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + CNT_Q'(1);
        end else if (rd && !wr) begin
            n_cnt = r_cnt - CNT_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wp <= (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            end
            if (rd) begin
                r_rp <= (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

### rtl/gdec_back.sv
// Back end: emits one digit slice per cycle into an output register that is empty or popped.
module gdec_back
    import gdec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_work     i_q_data,
    output logic      o_q_rd,
    output logic      o_empty,
    output t_out_item o_out,
    input  logic      i_pop
);

    logic               r_busy;
    logic               r_ov;
    logic [DIGIT_W-1:0] r_work;
    logic [K_W-1:0]     r_k;
    logic [K_W-1:0]     r_ell;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_s;
    logic               r_err;
    logic               r_pend;
    t_out_item          r_out;

    logic               adv;
    logic               emit;
    logic               last;
    logic               load;
    logic [DIGIT_W-1:0] field;
    logic [DIGIT_W-1:0] half;
    t_out_item          n_out;

    assign adv    = !r_ov || i_pop;
    assign emit   = r_busy && adv;
    assign last   = (r_s + CNT_W'(1)) == r_cnt;
    assign load   = (!r_busy || (emit && last)) && !i_q_empty;
    assign o_q_rd = load;
    assign o_empty = !r_ov;
    assign o_out   = r_out;

    // top k bits of the aligned sum, minus the per-digit offset
    always_comb begin
        field = r_work >> (K_W'(DIGIT_W) - r_k);
        half  = DIGIT_W'(1) << (r_k - K_W'(1));
        n_out.digit        = (!r_err && (r_s < {1'b0, r_ell})) ? (field - half) : '0;
        n_out.slice_index  = r_s[IDX_W-1:0];
        n_out.last_digit   = last;
        n_out.poly_end     = r_pend;
        n_out.config_error = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            if (load) begin
                r_busy <= (i_q_data.cnt != '0);
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
        if (load) begin
            r_work <= i_q_data.work;
            r_k    <= i_q_data.k;
            r_ell  <= i_q_data.ell;
            r_cnt  <= i_q_data.cnt;
            r_err  <= i_q_data.err;
            r_pend <= i_q_data.pend;
            r_s    <= '0;
        end else if (emit) begin
            r_work <= r_work << r_k;
            r_s    <= r_s + CNT_W'(1);
        end
    end

endmodule

### rtl/torus_gadget_decompose.sv
// Top level: signed gadget decomposition of torus coefficients into digit slices.
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------------
//  input     in         i_push / o_full        i_in  (torus_value, last_coeff)
//  result    out        o_empty / i_pop        o_out (digit, slice_index, last_digit,
//                                                     poly_end, config_error)
//  config    in         i_cfg_wr_en            i_cfg_addr, i_cfg_wdata (no read-back)
//
// Flow: a coefficient passes three front stages, then the slice sequencer
//   emits one slice per cycle while its output register is empty or popped,
//   and none if zero slices are requested; the sequencer sets the rate.
// Reset: synchronous, active low; clears config to 10/3/3 and empties the pipe.
// Stalls: a four-entry queue splits front and back; the front holds when the
//   queue is full, the back holds while the output register is not popped.
module torus_gadget_decompose
    import gdec_pkg::*;
#(
    parameter int MAX_SLICES    = DEF_MAX_SLICES,
    parameter int MAX_PRECISION = DEF_MAX_PRECISION
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_push,
    input  t_in_item              i_in,
    output logic                  o_full,
    output logic                  o_empty,
    output t_out_item             o_out,
    input  logic                  i_pop
);

    // front-to-queue and queue-to-back transactions
    logic  q_wr;
    t_work q_wdata;
    logic  q_full;
    logic  q_rd;
    t_work q_rdata;
    logic  q_empty;

    // front: rounds to L bits, adds the per-digit offset, left-aligns the sum
    gdec_front #(
        .MAX_SLICES    (MAX_SLICES),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_wr        (q_wr),
        .o_wdata     (q_wdata),
        .i_q_full    (q_full)
    );

    gdec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    // back: walks the slices most significant first, zero past digit_count
    gdec_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_rd    (q_rd),
        .o_empty   (o_empty),
        .o_out     (o_out),
        .i_pop     (i_pop)
    );

    // front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_wr |-> !q_full)
        else $error("queue write while full");

    // back never loads from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_empty)
        else $error("queue read while empty");

    // a bad configuration only ever yields zero digits
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.config_error) |-> (o_out.digit == '0))
        else $error("nonzero digit under config error");

    // a slice after a popped non-final slice continues the same coefficient
    a_slice_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_out.last_digit) ##1 !o_empty
        |-> (o_out.slice_index == $past(o_out.slice_index) + IDX_W'(1)))
        else $error("slice index out of sequence");

endmodule
